// ===== rtl/signed_int_to_decimal_text_unit_assert.svh =====
// Assertion macros for the signed integer to decimal text unit.
// Used by the port checker; needs nothing else.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SITD_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SITD_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/sitd_pkg.sv =====
// Shared types and constants of the signed integer to decimal text unit.
// No dependencies; used by the top level and the port checker.
package sitd_pkg;

  localparam int DATA_W        = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int DABBLE_STAGES = 4;
  localparam int STEPS         = DATA_W / DABBLE_STAGES;
  localparam int NUM_STAGES    = DABBLE_STAGES + 1;

  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_NINE  = 7'd57;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [3:0]       digit_idx_t;

  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] bin;
    bcd_t              bcd;
  } stage_t;

  // A block of shift-and-add-3 steps that moves STEPS magnitude bits into the BCD word.
  function automatic stage_t dabble_steps(stage_t s);
    stage_t r;
    r = s;
    for (int k = 0; k < STEPS; k++) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (r.bcd[j*4 +: 4] >= 4'd5) begin
          r.bcd[j*4 +: 4] = r.bcd[j*4 +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[DATA_W-1]};
      r.bin = {r.bin[DATA_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Position of the most significant nonzero digit, zero when all digits are zero.
  function automatic digit_idx_t msd_index(bcd_t b);
    digit_idx_t r;
    r = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (b[j*4 +: 4] != 4'd0) begin
        r = digit_idx_t'(j);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/signed_int_to_decimal_text_unit.sv =====
// Signed 32-bit integer to decimal ASCII text converter.
// Depends on sitd_pkg.
//
// Usage:
//   Input channel: value with in_valid / in_stall. A request is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: text_char and last with out_valid / out_stall. Each request
//   gives its text one character per cycle while out_stall is low, a sign first
//   if negative, most significant digit next, with last set on the final digit.
//   Path: a taken request passes one sign/magnitude stage, four binary-to-BCD
//   stages of eight steps each, then the character serializer, before its first
//   character shows.
//   Throughput: the serializer emits one character per cycle while out_stall is
//   low, and a number's text is one to eleven characters long; up to five further
//   requests wait in the conversion stages meanwhile.
//   Reset clears all valid bits and the serializer's busy and sign flags only.
//   When out_stall is high the shown character holds and the stages fill up;
//   in_stall rises once the first stage cannot move.
module signed_int_to_decimal_text_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         text_char,
  output logic               last
);

  sitd_pkg::stage_t                       st [sitd_pkg::NUM_STAGES];
  logic [sitd_pkg::NUM_STAGES-1:0]        vld;
  logic [sitd_pkg::NUM_STAGES-1:0]        adv;
  logic [sitd_pkg::DATA_W-1:0]            raw;

  logic                  busy, busy_next;
  logic                  sign_pend, sign_pend_next;
  sitd_pkg::bcd_t        digs, digs_next;
  sitd_pkg::digit_idx_t  pos, pos_next;
  logic                  out_acc;
  logic                  load_ok;

  assign raw = $unsigned(value);

  assign out_acc = busy && !out_stall;
  assign last    = !sign_pend && (pos == '0);
  assign load_ok = !busy || (out_acc && last);

  // A stage may take new data when it is empty or its content moves on.
  always_comb begin
    adv[sitd_pkg::NUM_STAGES-1] = !vld[sitd_pkg::NUM_STAGES-1] || load_ok;
    for (int i = sitd_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < sitd_pkg::NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0].neg <= raw[sitd_pkg::DATA_W-1];
      st[0].bin <= raw[sitd_pkg::DATA_W-1] ? (~raw + 1'b1) : raw;
      st[0].bcd <= '0;
    end
    for (int i = 1; i < sitd_pkg::NUM_STAGES; i++) begin
      if (adv[i]) begin
        st[i] <= sitd_pkg::dabble_steps(st[i-1]);
      end
    end
  end

  // Serializer: any sign goes out first, then digits from the most significant down.
  always_comb begin
    busy_next      = busy;
    sign_pend_next = sign_pend;
    digs_next      = digs;
    pos_next       = pos;
    if (load_ok) begin
      busy_next      = vld[sitd_pkg::NUM_STAGES-1];
      sign_pend_next = st[sitd_pkg::NUM_STAGES-1].neg;
      digs_next      = st[sitd_pkg::NUM_STAGES-1].bcd;
      pos_next       = sitd_pkg::msd_index(st[sitd_pkg::NUM_STAGES-1].bcd);
    end else if (out_acc) begin
      if (sign_pend) begin
        sign_pend_next = 1'b0;
      end else begin
        pos_next = pos - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
    end else begin
      busy      <= busy_next;
      sign_pend <= sign_pend_next;
    end
    digs <= digs_next;
    pos  <= pos_next;
  end

  assign out_valid = busy;
  assign text_char = sign_pend ? sitd_pkg::CHAR_MINUS
                               : sitd_pkg::CHAR_ZERO + {3'b000, digs[pos*4 +: 4]};

endmodule

// ===== rtl/sitd_checker.sv =====
// Port-level checker for the signed integer to decimal text unit, with its bind.
// Depends on sitd_pkg and signed_int_to_decimal_text_unit_assert.svh.
`include "signed_int_to_decimal_text_unit_assert.svh"

module sitd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] value,
  input logic               out_valid,
  input logic               out_stall,
  input logic [6:0]         text_char,
  input logic               last
);

  logic out_acc;
  logic is_minus;
  logic is_digit;

  assign out_acc  = out_valid && !out_stall;
  assign is_minus = text_char == sitd_pkg::CHAR_MINUS;
  assign is_digit = (text_char >= sitd_pkg::CHAR_ZERO) && (text_char <= sitd_pkg::CHAR_NINE);

  // A stalled character holds until it is taken.
  `SITD_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(text_char) && $stable(last))
  // Only a sign or a digit ever leaves the block.
  `SITD_ASSERT_NOW(a_charset, clk, rst, out_valid, is_minus || is_digit)
  // A sign never ends a number.
  `SITD_ASSERT_NOW(a_minus_not_last, clk, rst, out_valid && is_minus, !last)
  // The digit after a sign is a leading digit, so never zero.
  `SITD_ASSERT_NEXT(a_after_minus, clk, rst, out_acc && is_minus, out_valid && is_digit && (text_char != sitd_pkg::CHAR_ZERO))
  // Characters of one number follow without a gap.
  `SITD_ASSERT_NEXT(a_no_gap, clk, rst, out_acc && !last, out_valid)

endmodule

bind signed_int_to_decimal_text_unit sitd_checker u_sitd_checker (.*);
